>>> rtl/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// Types, constants and the binomial table of the Bezier point evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

  localparam int MAX_POINTS = 16;
  localparam int PIDX_W     = $clog2(MAX_POINTS);
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int COORD_W    = 24;
  localparam int PARAM_W    = 17;
  localparam int FRAC_W     = 16;
  localparam int POW_W      = 17;
  localparam int BINOM_W    = MAX_POINTS - 1;
  localparam int MUL_A_W    = POW_W + BINOM_W;
  localparam int MUL_B_W    = COORD_W + 1;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W + 1;
  localparam int ACC_W      = MUL_P_W + PIDX_W + 1;

  localparam int COORD_MAX  = 8388607;
  localparam int COORD_MIN  = -8388608;
  localparam int Q16_ONE    = 65536;
  localparam int ROUND_HALF = 32768;
  localparam int CNT_RESET  = 4;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [IDX_W-1:0]          point_index;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [PARAM_W-1:0]        param_u;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic                      we;
    logic [PIDX_W-1:0]         addr;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } store_wr_t;

  localparam int BTAB_W = MAX_POINTS * MAX_POINTS * BINOM_W;

  // pascal triangle, row n holds C(n, k)
  function automatic logic [BTAB_W-1:0] binom_tab_f();
    int                row [MAX_POINTS];
    logic [BTAB_W-1:0] tab;
    tab = '0;
    for (int k = 0; k < MAX_POINTS; k++) row[k] = 0;
    row[0] = 1;
    for (int n = 0; n < MAX_POINTS; n++) begin
      if (n > 0) begin
        for (int k = MAX_POINTS - 1; k > 0; k--) row[k] = row[k] + row[k-1];
      end
      for (int k = 0; k < MAX_POINTS; k++) begin
        tab[(n*MAX_POINTS + k)*BINOM_W +: BINOM_W] = BINOM_W'(row[k]);
      end
    end
    return tab;
  endfunction

  localparam logic [BTAB_W-1:0] BINOM_TAB = binom_tab_f();

  function automatic logic [BINOM_W-1:0] binom_f(input logic [PIDX_W-1:0] n,
                                                 input logic [PIDX_W-1:0] k);
    return BINOM_TAB[(int'(n)*MAX_POINTS + int'(k))*BINOM_W +: BINOM_W];
  endfunction

endpackage

>>> rtl/bpe_mul.sv
// ----------------------------------------------------------------------------
// bpe_mul
// Shared multiplier: unsigned a times signed b, product registered.
// ----------------------------------------------------------------------------
module bpe_mul
  import bpe_pkg::*;
(
  input  logic                      clk,
  input  logic [MUL_A_W-1:0]        mul_a,
  input  logic signed [MUL_B_W-1:0] mul_b,
  output logic signed [MUL_P_W-1:0] mul_p_r
);

  logic signed [MUL_A_W:0]   a_s;
  logic signed [MUL_P_W-1:0] mul_p_nxt;

  assign a_s       = {1'b0, mul_a};
  assign mul_p_nxt = a_s * mul_b;

  always_ff @(posedge clk) begin
    mul_p_r <= mul_p_nxt;
  end

endmodule

>>> rtl/bpe_point_store.sv
// ----------------------------------------------------------------------------
// bpe_point_store
// Control point memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bpe_point_store
  import bpe_pkg::*;
(
  input  logic                      clk,
  input  store_wr_t                 wr,
  input  logic [PIDX_W-1:0]         rd_addr,
  output logic signed [COORD_W-1:0] rd_x_r,
  output logic signed [COORD_W-1:0] rd_y_r
);

  logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
  logic signed [COORD_W-1:0] mem_y [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_x[wr.addr] <= wr.x;
      mem_y[wr.addr] <= wr.y;
    end
  end

  always_ff @(posedge clk) begin
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

endmodule

>>> rtl/bezier_point_evaluator_unit.sv
// ----------------------------------------------------------------------------
// bezier_point_evaluator_unit
// Bezier curve point in Bernstein form, one shared multiplier under a
// sequencer; saturated Q15.8 result with a clip flag.
// ----------------------------------------------------------------------------
// channel   ports                          transfer when
// input     start, busy, in_data           start && !busy
// result    out_valid, out_data            out_valid (one cycle strobe)
// config    cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//
// a point write leaves busy low
// an evaluate keeps busy high while the single multiplier steps through
// ST_PU, ST_PV, ST_PW per power of u and 1-u, then ST_WA to ST_WE per point
// and ST_FIN; the result strobe is registered from ST_FIN, busy is low with it,
// and the next start is taken in that same cycle
// reset is synchronous, point_count returns to 4, the store is not cleared
// the receiver cannot stall, cfg_ready is always high
// ----------------------------------------------------------------------------
module bezier_point_evaluator_unit
  import bpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PU   = 4'd1;
  localparam logic [3:0] ST_PV   = 4'd2;
  localparam logic [3:0] ST_PW   = 4'd3;
  localparam logic [3:0] ST_WA   = 4'd4;
  localparam logic [3:0] ST_WB   = 4'd5;
  localparam logic [3:0] ST_WC   = 4'd6;
  localparam logic [3:0] ST_WD   = 4'd7;
  localparam logic [3:0] ST_WE   = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;

  logic [3:0]                state_r, state_nxt;
  logic [CNT_W-1:0]          point_count_r;
  logic [PIDX_W-1:0]         n_r, n_nxt;
  logic [PIDX_W-1:0]         k_r, k_nxt;
  logic [PIDX_W-1:0]         i_r, i_nxt;
  logic [POW_W-1:0]          u_r, u_nxt;
  logic [POW_W-1:0]          v_r, v_nxt;
  logic [POW_W-1:0]          pul_r, pul_nxt;
  logic [POW_W-1:0]          pvl_r, pvl_nxt;
  logic [MUL_A_W-1:0]        w_r, w_nxt;
  logic signed [ACC_W-1:0]   accx_r, accx_nxt;
  logic signed [ACC_W-1:0]   accy_r, accy_nxt;
  logic [POW_W-1:0]          pu_r [MAX_POINTS];
  logic [POW_W-1:0]          pv_r [MAX_POINTS];
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  logic                      pw_we;
  logic [PIDX_W-1:0]         pw_addr;
  logic [POW_W-1:0]          pu_wd;
  logic [POW_W-1:0]          pv_wd;

  logic                      in_xfer;
  logic [CNT_W-1:0]          cnt_c;
  logic [PIDX_W-1:0]         n_eval;
  logic [POW_W-1:0]          u_sat;
  logic [PIDX_W-1:0]         nmi;
  logic [MUL_A_W-1:0]        mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p_r;
  logic [POW_W-1:0]          p_rnd;
  logic signed [COORD_W-1:0] rd_x_r;
  logic signed [COORD_W-1:0] rd_y_r;
  store_wr_t                 st_wr;
  logic [COORD_W:0]          fin_x;
  logic [COORD_W:0]          fin_y;

  function automatic logic [POW_W-1:0] rnd_q16_f(input logic signed [MUL_P_W-1:0] p);
    logic [MUL_P_W-1:0] t;
    t = MUL_P_W'(p) + MUL_P_W'(ROUND_HALF);
    return t[FRAC_W +: POW_W];
  endfunction

  // returns {clip, value}
  function automatic logic [COORD_W:0] sat_round_f(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    t = (acc + ACC_W'(ROUND_HALF)) >>> FRAC_W;
    if (t > ACC_W'(COORD_MAX)) begin
      return {1'b1, COORD_W'(COORD_MAX)};
    end else if (t < ACC_W'(COORD_MIN)) begin
      return {1'b1, COORD_W'(COORD_MIN)};
    end
    return {1'b0, t[COORD_W-1:0]};
  endfunction

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_xfer   = start && !busy;

  always_comb begin
    if (point_count_r == '0) begin
      cnt_c = CNT_W'(1);
    end else if (int'(point_count_r) > MAX_POINTS) begin
      cnt_c = CNT_W'(MAX_POINTS);
    end else begin
      cnt_c = point_count_r;
    end
  end

  assign n_eval = PIDX_W'(cnt_c - CNT_W'(1));
  assign u_sat  = (int'(in_data.param_u) > Q16_ONE) ? POW_W'(Q16_ONE) : in_data.param_u;
  assign nmi    = n_r - i_r;
  assign p_rnd  = rnd_q16_f(mul_p_r);
  assign fin_x  = sat_round_f(accx_r);
  assign fin_y  = sat_round_f(accy_r);

  assign st_wr.we   = in_xfer && (in_data.mode == MODE_WRITE) &&
                      (int'(in_data.point_index) < MAX_POINTS);
  assign st_wr.addr = in_data.point_index[PIDX_W-1:0];
  assign st_wr.x    = in_data.point_x;
  assign st_wr.y    = in_data.point_y;

  bpe_point_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd_addr (i_r),
    .rd_x_r  (rd_x_r),
    .rd_y_r  (rd_y_r)
  );

  bpe_mul u_mul (
    .clk     (clk),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .mul_p_r (mul_p_r)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    pul_nxt       = pul_r;
    pvl_nxt       = pvl_r;
    w_nxt         = w_r;
    accx_nxt      = accx_r;
    accy_nxt      = accy_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mul_a         = '0;
    mul_b         = '0;
    pw_we         = 1'b0;
    pw_addr       = k_r;
    pu_wd         = p_rnd;
    pv_wd         = p_rnd;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_data.mode == MODE_EVAL)) begin
          n_nxt     = n_eval;
          u_nxt     = u_sat;
          v_nxt     = POW_W'(Q16_ONE) - u_sat;
          pul_nxt   = POW_W'(Q16_ONE);
          pvl_nxt   = POW_W'(Q16_ONE);
          k_nxt     = PIDX_W'(1);
          i_nxt     = '0;
          accx_nxt  = '0;
          accy_nxt  = '0;
          pw_we     = 1'b1;
          pw_addr   = '0;
          pu_wd     = POW_W'(Q16_ONE);
          pv_wd     = POW_W'(Q16_ONE);
          state_nxt = (n_eval == '0) ? ST_WA : ST_PU;
        end
      end
      ST_PU: begin
        mul_a     = MUL_A_W'(pul_r);
        mul_b     = MUL_B_W'(u_r);
        state_nxt = ST_PV;
      end
      ST_PV: begin
        pul_nxt   = p_rnd;
        mul_a     = MUL_A_W'(pvl_r);
        mul_b     = MUL_B_W'(v_r);
        state_nxt = ST_PW;
      end
      ST_PW: begin
        pvl_nxt = p_rnd;
        pw_we   = 1'b1;
        pu_wd   = pul_r;
        if (k_r == n_r) begin
          i_nxt     = '0;
          state_nxt = ST_WA;
        end else begin
          k_nxt     = k_r + PIDX_W'(1);
          state_nxt = ST_PU;
        end
      end
      ST_WA: begin
        mul_a     = MUL_A_W'(pu_r[i_r]);
        mul_b     = MUL_B_W'(pv_r[nmi]);
        state_nxt = ST_WB;
      end
      ST_WB: begin
        mul_a     = MUL_A_W'(p_rnd);
        mul_b     = MUL_B_W'(binom_f(n_r, i_r));
        state_nxt = ST_WC;
      end
      ST_WC: begin
        w_nxt     = mul_p_r[MUL_A_W-1:0];
        mul_a     = mul_p_r[MUL_A_W-1:0];
        mul_b     = MUL_B_W'(rd_x_r);
        state_nxt = ST_WD;
      end
      ST_WD: begin
        accx_nxt  = accx_r + ACC_W'(mul_p_r);
        mul_a     = w_r;
        mul_b     = MUL_B_W'(rd_y_r);
        state_nxt = ST_WE;
      end
      ST_WE: begin
        accy_nxt = accy_r + ACC_W'(mul_p_r);
        if (i_r == n_r) begin
          state_nxt = ST_FIN;
        end else begin
          i_nxt     = i_r + PIDX_W'(1);
          state_nxt = ST_WA;
        end
      end
      ST_FIN: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.curve_x   = fin_x[COORD_W-1:0];
        out_data_nxt.curve_y   = fin_y[COORD_W-1:0];
        out_data_nxt.saturated = fin_x[COORD_W] | fin_y[COORD_W];
        state_nxt              = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      point_count_r <= CNT_W'(CNT_RESET);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        point_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    pul_r      <= pul_nxt;
    pvl_r      <= pvl_nxt;
    w_r        <= w_nxt;
    accx_r     <= accx_nxt;
    accy_r     <= accy_nxt;
    out_data_r <= out_data_nxt;
    if (pw_we) begin
      pu_r[pw_addr] <= pu_wd;
      pv_r[pw_addr] <= pv_wd;
    end
  end

  // result strobe only after the final step
  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_FIN))
    else $error("result strobe without final step");

  // evaluate transfer starts the sequencer
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_data.mode == MODE_EVAL)) |=> busy)
    else $error("evaluate did not start");

  // point write leaves the sequencer idle
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_data.mode == MODE_WRITE)) |=> !busy && !out_valid)
    else $error("point write disturbed the sequencer");

  // point and power counters stay within the degree
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (i_r <= n_r) && (k_r <= n_r || n_r == '0))
    else $error("counter beyond curve degree");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks bezier_point_evaluator_unit against a behavioral curve predictor.
// Control points and evaluates go in through the start/busy port with random
// gaps. The point count is changed between phases while the block is idle,
// with values from 0 to 31. Each result strobe is compared field by field
// with the oldest predicted curve point.
// ----------------------------------------------------------------------------
module testbench;
  import bpe_pkg::*;

  class curve_scoreboard;
    logic [CNT_W-1:0]          point_count;
    logic signed [COORD_W-1:0] ctrl_x [MAX_POINTS];
    logic signed [COORD_W-1:0] ctrl_y [MAX_POINTS];
    out_item_t                 expected_points [$];
    int                        mismatches;

    function new();
      point_count = CNT_W'(CNT_RESET);
      mismatches  = 0;
      foreach (ctrl_x[k]) begin
        ctrl_x[k] = '0;
        ctrl_y[k] = '0;
      end
    endfunction

    function void report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 100) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void set_count(logic [CNT_W-1:0] c);
      point_count = c;
    endfunction

    function longint unsigned round_mul(longint unsigned a, longint unsigned b);
      return (a * b + ROUND_HALF) >> FRAC_W;
    endfunction

    function longint sat_coord(longint val, inout bit clip);
      if (val > COORD_MAX) begin
        clip = 1'b1;
        return COORD_MAX;
      end
      if (val < COORD_MIN) begin
        clip = 1'b1;
        return COORD_MIN;
      end
      return val;
    endfunction

    function out_item_t eval_curve(logic [PARAM_W-1:0] u_in);
      int              cnt;
      int              deg;
      longint unsigned u;
      longint unsigned v;
      longint unsigned binom;
      longint unsigned w;
      longint unsigned pu [MAX_POINTS];
      longint unsigned pv [MAX_POINTS];
      longint          acc_x;
      longint          acc_y;
      longint          rx;
      longint          ry;
      bit              clip;
      out_item_t       r;
      cnt = int'(point_count);
      if (cnt < 1) cnt = 1;
      if (cnt > MAX_POINTS) cnt = MAX_POINTS;
      deg = cnt - 1;
      u = (u_in > Q16_ONE) ? Q16_ONE : u_in;
      v = Q16_ONE - u;
      pu[0] = Q16_ONE;
      pv[0] = Q16_ONE;
      for (int i = 1; i <= deg; i++) begin
        pu[i] = round_mul(pu[i-1], u);
        pv[i] = round_mul(pv[i-1], v);
      end
      binom = 1;
      acc_x = 0;
      acc_y = 0;
      for (int i = 0; i <= deg; i++) begin
        w = round_mul(pu[i], pv[deg-i]) * binom;
        acc_x += longint'(w) * longint'(ctrl_x[i]);
        acc_y += longint'(w) * longint'(ctrl_y[i]);
        binom = binom * longint'(deg - i) / longint'(i + 1);
      end
      // round half up, floor via arithmetic shift
      clip = 1'b0;
      rx = sat_coord((acc_x + ROUND_HALF) >>> FRAC_W, clip);
      ry = sat_coord((acc_y + ROUND_HALF) >>> FRAC_W, clip);
      r.curve_x   = COORD_W'(rx);
      r.curve_y   = COORD_W'(ry);
      r.saturated = clip;
      return r;
    endfunction

    function void note_input(in_item_t it);
      if (it.mode == MODE_WRITE) begin
        ctrl_x[it.point_index] = it.point_x;
        ctrl_y[it.point_index] = it.point_y;
      end else begin
        expected_points.push_back(eval_curve(it.param_u));
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_pt;
      if (expected_points.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%h y=%h sat=%b",
                                  got.curve_x, got.curve_y, got.saturated));
        return;
      end
      exp_pt = expected_points.pop_front();
      if (got.curve_x !== exp_pt.curve_x)
        report_mismatch($sformatf("curve_x got %h exp %h", got.curve_x, exp_pt.curve_x));
      if (got.curve_y !== exp_pt.curve_y)
        report_mismatch($sformatf("curve_y got %h exp %h", got.curve_y, exp_pt.curve_y));
      if (got.saturated !== exp_pt.saturated)
        report_mismatch($sformatf("saturated got %b exp %b",
                                  got.saturated, exp_pt.saturated));
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_data;
  logic             out_valid;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  curve_scoreboard  sb;
  logic [MAX_POINTS-1:0] slot_written;
  int               active_count;
  bit               idle_enable;

  bezier_point_evaluator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 7))
      0: return COORD_W'(COORD_MAX);
      1: return COORD_W'(COORD_MIN);
      2: return COORD_W'(int'($urandom_range(0, 511)) - 256);
      default: return COORD_W'($urandom());
    endcase
  endfunction

  function automatic logic [PARAM_W-1:0] random_param();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return PARAM_W'(Q16_ONE);
      2: return PARAM_W'($urandom_range(Q16_ONE + 1, 131071));
      default: return PARAM_W'($urandom_range(0, Q16_ONE));
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    @(negedge clk);
    while (idle_enable && $urandom_range(0, 99) < 12) begin
      start   = 1'b0;
      in_data = in_item_t'({$urandom(), $urandom(), $urandom()});
      @(negedge clk);
    end
    start   = 1'b1;
    in_data = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_input(it);
  endtask

  task automatic send_point(int idx, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y);
    in_item_t it;
    it.mode        = MODE_WRITE;
    it.point_index = IDX_W'(idx);
    it.point_x     = x;
    it.point_y     = y;
    it.param_u     = PARAM_W'($urandom());
    slot_written[idx] = 1'b1;
    send_item(it);
  endtask

  task automatic send_eval(logic [PARAM_W-1:0] u);
    in_item_t it;
    it.mode        = MODE_EVAL;
    it.point_index = IDX_W'($urandom());
    it.point_x     = random_coord();
    it.point_y     = random_coord();
    it.param_u     = u;
    send_item(it);
  endtask

  // drop start, let every expected point arrive, then allow the longest pass
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (8 * MAX_POINTS + 16) @(posedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] c);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = c;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.set_count(c);
    active_count = (c < 1) ? 1 : ((c > MAX_POINTS) ? MAX_POINTS : int'(c));
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_random(int num);
    int unsigned need;
    int          first_free;
    for (int k = 0; k < num; k++) begin
      need = (32'd1 << active_count) - 1;
      if ($urandom_range(0, 99) < 40) begin
        send_point($urandom_range(0, MAX_POINTS - 1), random_coord(), random_coord());
      end else if ((need & slot_written) != need) begin
        first_free = 0;
        while (slot_written[first_free]) first_free++;
        send_point(first_free, random_coord(), random_coord());
      end else begin
        send_eval(random_param());
      end
    end
  endtask

  initial begin
    logic [CNT_W-1:0] counts [10];
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    slot_written = '0;
    active_count = CNT_RESET;
    idle_enable  = 1'b1;
    sb = new();
    counts = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd3, 5'd9, 5'd5, 5'd4};
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // corners of the points and of u at the reset count
    send_point(0, COORD_W'(COORD_MAX), COORD_W'(COORD_MIN));
    send_point(1, COORD_W'(COORD_MIN), COORD_W'(COORD_MAX));
    send_point(2, COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
    send_point(3, '0, '1);
    send_eval('0);
    send_eval(PARAM_W'(Q16_ONE));
    send_eval(PARAM_W'(1));
    send_eval(PARAM_W'(Q16_ONE - 1));
    send_eval(PARAM_W'(ROUND_HALF));
    send_eval(17'h1FFFF);
    for (int k = 0; k < 4; k++) send_point(k, COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
    send_eval(PARAM_W'(21845));
    send_eval(PARAM_W'(43690));
    send_eval(PARAM_W'(12345));
    for (int k = 0; k < 4; k++) send_point(k, COORD_W'(COORD_MIN), COORD_W'(COORD_MIN));
    send_eval(PARAM_W'(21845));
    send_eval(PARAM_W'(50000));

    foreach (counts[p]) begin
      write_count(counts[p]);
      // one phase with a back-to-back stretch
      idle_enable = (p != 0);
      run_random(165);
    end
    drain();

    if (sb.expected_points.size() != 0)
      sb.report_mismatch($sformatf("%0d curve points never arrived",
                                   sb.expected_points.size()));
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
